// ===== design/bave_pkg.sv =====
package bave_pkg;

    localparam int RING_DEPTH_DEF = 5;

    // widths fixed by the field formats
    localparam int ALT_W   = 24;
    localparam int DT_W    = 20;
    localparam int ALPHA_W = 17;
    localparam int CFG_W   = 24;

    // shared divider: |dAlt * 1e6| < 2^45, divisor up to 20 bits
    localparam int DIV_N_W = 45;
    localparam int DIV_D_W = 20;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd52429;
    localparam logic signed [20:0] US_PER_S    = 21'sd1000000;

    localparam logic signed [ALT_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [ALT_W-1:0] S24_MIN = 24'sh800000;

    // configuration register indexes
    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_PAD   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_WAIT,
        ST_FILT_USE,
        ST_SPD_LOAD,
        ST_SPD_WAIT,
        ST_SPD_START,
        ST_SPD_DIV,
        ST_SUM,
        ST_MEAN_START,
        ST_MEAN_DIV,
        ST_SM_LOAD,
        ST_SM_WAIT,
        ST_SM_USE,
        ST_DONE
    } state_t;

    function automatic logic signed [ALT_W-1:0] sat24(input logic signed [ALT_W:0] v);
        logic signed [ALT_W-1:0] r;
        if (v > 25'sd8388607) begin
            r = S24_MAX;
        end else if (v < -25'sd8388608) begin
            r = S24_MIN;
        end else begin
            r = v[ALT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bave_divider.sv =====
module bave_divider
    import bave_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output div_status_t        status
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               qbit;
    logic [DIV_D_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle shifted into num_reg
    always_comb begin
        trial    = {rem_reg, num_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_N_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== design/baro_altitude_velocity_estimator.sv =====
// s_ready is high only when idle: a new item is accepted only after the last one
// has been loaded into the output register. The time per item goes to two passes
// of the shared 45-step divider (speed and ring mean), the ring sum (one entry a
// cycle) and three trips through the shared multiplier.
// Reset (synchronous, aresetn low): alpha 52429, pad 0, filter states, ring, slot
// and peak cleared to zero; no output item pending.
module baro_altitude_velocity_estimator
    import bave_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic                    cfg_idx,
    input  logic [CFG_W-1:0]        cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [ALT_W-1:0] s_raw_altitude,
    input  logic [DT_W-1:0]         s_elapsed_us,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ALT_W-1:0] m_filtered_altitude,
    output logic signed [ALT_W-1:0] m_height_above_pad,
    output logic signed [ALT_W-1:0] m_vertical_speed,
    output logic signed [ALT_W-1:0] m_peak_height
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W  = ALT_W + 1 + $clog2(RING_DEPTH);

    state_t state_reg, state_next;

    // configuration
    logic [ALPHA_W-1:0]      alpha_reg;
    logic signed [ALT_W-1:0] pad_reg;

    // persistent state
    logic signed [ALT_W-1:0] last_alt_reg;
    logic signed [ALT_W-1:0] last_speed_reg;
    logic signed [ALT_W-1:0] peak_reg;
    logic signed [ALT_W-1:0] ring_reg [RING_DEPTH];
    logic [SLOT_W-1:0]       slot_reg;

    // per-item working registers
    logic signed [ALT_W-1:0] x_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [ALT_W-1:0] filt_reg;
    logic signed [ALT_W-1:0] height_reg;
    logic signed [ALT_W-1:0] mean_reg;
    logic signed [ALT_W-1:0] smooth_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SLOT_W-1:0]       idx_reg;
    logic                    neg_reg;

    // shared multiplier
    logic signed [ALT_W:0]   mul_a_reg;
    logic signed [20:0]      mul_b_reg;
    logic signed [45:0]      p_reg;

    // output register
    logic                    m_valid_reg;
    logic signed [ALT_W-1:0] out_filt_reg;
    logic signed [ALT_W-1:0] out_height_reg;
    logic signed [ALT_W-1:0] out_speed_reg;
    logic signed [ALT_W-1:0] out_peak_reg;

    // divider
    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [DIV_N_W-1:0] quot;
    div_status_t        div_st;

    logic                    out_load;
    logic signed [45:0]      p_rnd;
    logic signed [45:0]      p_neg;
    logic [DIV_N_W-1:0]      p_mag;
    logic signed [ALT_W-1:0] lp_base;
    logic signed [29:0]      lp_full;
    logic signed [SUM_W-1:0] sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [ALT_W-1:0] speed_sat;
    logic signed [ALT_W:0]   mean_pos;
    logic signed [ALT_W:0]   mean_full;
    logic signed [ALT_W-1:0] peak_new;
    logic signed [ALT_W-1:0] alpha_op;

    bave_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quot),
        .status   (div_st)
    );

    // ---------------- datapath helpers ----------------
    always_comb begin
        // low-pass: base + floor((a*(prev-base) + 2^15) / 2^16)
        p_rnd   = p_reg + 46'sd32768;
        lp_base = (state_reg == ST_SM_USE) ? mean_reg : x_reg;
        lp_full = 30'(lp_base) + $signed(p_rnd[45:16]);

        p_neg = -p_reg;
        p_mag = p_reg[45] ? p_neg[DIV_N_W-1:0] : p_reg[DIV_N_W-1:0];

        sum_neg = -sum_reg;
        sum_mag = sum_reg[SUM_W-1] ? sum_neg : sum_reg;

        if (neg_reg) begin
            speed_sat = (quot > DIV_N_W'(8388608)) ? S24_MIN : (~quot[ALT_W-1:0] + 1'b1);
        end else begin
            speed_sat = (quot > DIV_N_W'(8388607)) ? S24_MAX : quot[ALT_W-1:0];
        end

        mean_pos  = {1'b0, quot[ALT_W-1:0]};
        mean_full = neg_reg ? -mean_pos : mean_pos;

        peak_new = (height_reg > peak_reg) ? height_reg : peak_reg;
        alpha_op = ALT_W'(alpha_reg);

        div_dividend = (state_reg == ST_MEAN_START) ? DIV_N_W'(sum_mag) : p_mag;
        div_divisor  = (state_reg == ST_MEAN_START) ? DIV_D_W'(RING_DEPTH) : dt_reg;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_FILT_WAIT;
                end
            end
            ST_FILT_WAIT:  state_next = ST_FILT_USE;
            ST_FILT_USE:   state_next = ST_SPD_LOAD;
            ST_SPD_LOAD:   state_next = ST_SPD_WAIT;
            ST_SPD_WAIT:   state_next = ST_SPD_START;
            ST_SPD_START: begin
                div_start  = 1'b1;
                state_next = ST_SPD_DIV;
            end
            ST_SPD_DIV: begin
                if (div_st.done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (idx_reg == SLOT_W'(RING_DEPTH - 1)) begin
                    state_next = ST_MEAN_START;
                end
            end
            ST_MEAN_START: begin
                div_start  = 1'b1;
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                if (div_st.done) begin
                    state_next = ST_SM_LOAD;
                end
            end
            ST_SM_LOAD:    state_next = ST_SM_WAIT;
            ST_SM_WAIT:    state_next = ST_SM_USE;
            ST_SM_USE:     state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // multiplier runs every cycle; operands loaded by the sequencer
    always_ff @(posedge aclk) begin
        p_reg <= mul_a_reg * mul_b_reg;
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg     <= s_raw_altitude;
                dt_reg    <= (s_elapsed_us == '0) ? DT_W'(1) : s_elapsed_us;
                mul_a_reg <= (ALT_W+1)'(last_alt_reg) - (ALT_W+1)'(s_raw_altitude);
                mul_b_reg <= 21'(alpha_op);
            end
            ST_FILT_USE: begin
                filt_reg <= lp_full[ALT_W-1:0];
            end
            ST_SPD_LOAD: begin
                height_reg <= sat24((ALT_W+1)'(filt_reg) - (ALT_W+1)'(pad_reg));
                mul_a_reg  <= (ALT_W+1)'(filt_reg) - (ALT_W+1)'(last_alt_reg);
                mul_b_reg  <= US_PER_S;
            end
            ST_SPD_START: begin
                neg_reg <= p_reg[45];
            end
            ST_SPD_DIV: begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            ST_SUM: begin
                sum_reg <= sum_reg + SUM_W'(ring_reg[idx_reg]);
                idx_reg <= idx_reg + 1'b1;
            end
            ST_MEAN_START: begin
                neg_reg <= sum_reg[SUM_W-1];
            end
            ST_MEAN_DIV: begin
                mean_reg <= mean_full[ALT_W-1:0];
            end
            ST_SM_LOAD: begin
                mul_a_reg <= (ALT_W+1)'(last_speed_reg) - (ALT_W+1)'(mean_reg);
                mul_b_reg <= 21'(alpha_op);
            end
            ST_SM_USE: begin
                smooth_reg <= lp_full[ALT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // configuration and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ALPHA_RESET;
            pad_reg        <= '0;
            last_alt_reg   <= '0;
            last_speed_reg <= '0;
            peak_reg       <= '0;
            slot_reg       <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_ALPHA: begin
                        alpha_reg <= (cfg_wdata[ALPHA_W-1:0] > ALPHA_ONE) ?
                                     ALPHA_ONE : cfg_wdata[ALPHA_W-1:0];
                    end
                    CFG_PAD: begin
                        pad_reg  <= cfg_wdata[ALT_W-1:0];
                        peak_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_SPD_DIV && div_st.done) begin
                ring_reg[slot_reg] <= speed_sat;
            end
            if (out_load) begin
                last_alt_reg   <= filt_reg;
                last_speed_reg <= smooth_reg;
                peak_reg       <= peak_new;
                slot_reg       <= (slot_reg == SLOT_W'(RING_DEPTH - 1)) ?
                                  '0 : slot_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_filt_reg   <= filt_reg;
            out_height_reg <= height_reg;
            out_speed_reg  <= smooth_reg;
            out_peak_reg   <= peak_new;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_filtered_altitude = out_filt_reg;
    assign m_height_above_pad  = out_height_reg;
    assign m_vertical_speed    = out_speed_reg;
    assign m_peak_height       = out_peak_reg;

    // ---------------- checks ----------------
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_st.busy && !div_st.done)
        else $error("divider active while idle");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(RING_DEPTH - 1))
        else $error("ring slot out of range");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result presented outside the done step");

endmodule
